/* hdl/assert_macros.svh */
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

/* hdl/cpp_pkg.sv */
`default_nettype none
package cpp_pkg;
    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int T_BITS_DEF     = 16;

    typedef struct packed {
        logic load;
        logic seg;
        logic div_step;
        logic proj;
        logic dist_calc;
        logic cmp;
        logic emit;
        logic clear;
        logic commit_prev;
    } cpp_cmd_t;

    typedef struct packed {
        logic div_skip;
        logic div_done;
        logic first;
        logic last;
        logic have_prev;
    } cpp_status_t;
endpackage
`default_nettype wire

/* hdl/cpp_if.sv */
`default_nettype none
interface cpp_in_if #(parameter int COORD_BITS = 24);
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic first_vertex;
    logic last_vertex;
    modport source (output valid, query_x, query_y, vertex_x, vertex_y, first_vertex,
                    last_vertex, input ready);
    modport sink (input valid, query_x, query_y, vertex_x, vertex_y, first_vertex,
                  last_vertex, output ready);
endinterface

interface cpp_out_if #(parameter int COORD_BITS = 24);
    logic valid;
    logic ready;
    logic found;
    logic signed [COORD_BITS-1:0] closest_x;
    logic signed [COORD_BITS-1:0] closest_y;
    modport source (output valid, found, closest_x, closest_y, input ready);
    modport sink (input valid, found, closest_x, closest_y, output ready);
endinterface
`default_nettype wire

/* hdl/cpp_ctrl.sv */
`default_nettype none
module cpp_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  wire logic out_ready,
    input  wire cpp_pkg::cpp_status_t status,
    output cpp_pkg::cpp_cmd_t cmd
);
    import cpp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SEG  = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_PROJ = 7'b0001000,
        S_DIST = 7'b0010000,
        S_CMP  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign out_valid = out_valid_reg;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                if (status.first)
                    cmd.clear = 1'b1;
                if (status.have_prev && !status.first)
                begin
                    cmd.seg = 1'b1;
                    state_next = S_DIV;
                end
                else
                    state_next = S_FIN;
            end
            S_DIV:
            begin
                if (status.div_skip)
                    state_next = S_DIST;
                else
                begin
                    cmd.div_step = 1'b1;
                    if (status.div_done)
                        state_next = S_PROJ;
                end
            end
            S_PROJ:
            begin
                cmd.proj = 1'b1;
                state_next = S_DIST;
            end
            S_DIST:
            begin
                cmd.dist_calc = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (status.last)
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        cmd.emit = 1'b1;
                        cmd.commit_prev = 1'b1;
                        out_valid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.commit_prev = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

/* hdl/cpp_datapath.sv */
`default_nettype none
module cpp_datapath #(
    parameter int COORD_BITS = cpp_pkg::COORD_BITS_DEF,
    parameter int T_BITS = cpp_pkg::T_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic signed [COORD_BITS-1:0] query_x,
    input  wire logic signed [COORD_BITS-1:0] query_y,
    input  wire logic signed [COORD_BITS-1:0] vertex_x,
    input  wire logic signed [COORD_BITS-1:0] vertex_y,
    input  wire logic first_vertex,
    input  wire logic last_vertex,
    input  wire cpp_pkg::cpp_cmd_t cmd,
    output cpp_pkg::cpp_status_t status,
    output logic found,
    output logic signed [COORD_BITS-1:0] closest_x,
    output logic signed [COORD_BITS-1:0] closest_y
);
    import cpp_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int LW = PW + 1;
    localparam int CW = $clog2(T_BITS + 1);

    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, vx_reg, vy_reg, ax_reg, ay_reg;
    logic first_reg, last_reg, have_prev_reg;
    logic signed [DW-1:0] abx_reg, aby_reg;
    logic [LW-1:0] l2_reg, rem_reg, best_reg;
    logic [T_BITS-1:0] t_reg;
    logic [CW-1:0] cnt_reg;
    logic skip_reg;
    logic signed [COORD_BITS-1:0] rx_reg, ry_reg, bx_reg, by_reg;
    logic [LW-1:0] dist_reg;
    logic best_valid_reg;
    logic found_reg;
    logic signed [COORD_BITS-1:0] ox_reg, oy_reg;

    logic signed [DW-1:0] abx, aby, apx, apy, dxn, dyn;
    logic signed [PW-1:0] dot;
    logic [LW-1:0] l2, shl;

    assign abx = DW'(vx_reg) - DW'(ax_reg);
    assign aby = DW'(vy_reg) - DW'(ay_reg);
    assign apx = DW'(qx_reg) - DW'(ax_reg);
    assign apy = DW'(qy_reg) - DW'(ay_reg);
    assign dot = PW'(apx) * PW'(abx) + PW'(apy) * PW'(aby);
    assign l2 = LW'($unsigned(PW'(abx) * PW'(abx))) + LW'($unsigned(PW'(aby) * PW'(aby)));
    assign shl = {rem_reg[LW-2:0], 1'b0};
    assign dxn = DW'(qx_reg) - DW'(rx_reg);
    assign dyn = DW'(qy_reg) - DW'(ry_reg);

    function automatic logic signed [DW+T_BITS:0] tz(logic signed [DW+T_BITS:0] p,
                                                    logic neg);
        logic signed [DW+T_BITS:0] m;
        m = neg ? -p : p;
        m = m >>> T_BITS;
        return neg ? -m : m;
    endfunction

    logic signed [DW+T_BITS:0] px_full, py_full, offx, offy;
    assign px_full = $signed({1'b0, t_reg}) * abx_reg;
    assign py_full = $signed({1'b0, t_reg}) * aby_reg;
    assign offx = tz(px_full, abx_reg[DW-1]);
    assign offy = tz(py_full, aby_reg[DW-1]);

    assign status.div_skip = skip_reg;
    assign status.div_done = (cnt_reg == CW'(1));
    assign status.first = first_reg || !have_prev_reg;
    assign status.last = last_reg;
    assign status.have_prev = have_prev_reg;
    assign found = found_reg;
    assign closest_x = ox_reg;
    assign closest_y = oy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            qx_reg <= query_x;
            qy_reg <= query_y;
            vx_reg <= vertex_x;
            vy_reg <= vertex_y;
            first_reg <= first_vertex;
            last_reg <= last_vertex;
        end
        if (cmd.seg)
        begin
            abx_reg <= abx;
            aby_reg <= aby;
            l2_reg <= l2;
            t_reg <= '0;
            cnt_reg <= CW'(T_BITS);
            rx_reg <= ax_reg;
            ry_reg <= ay_reg;
            if (dot <= 0)
            begin
                skip_reg <= 1'b1;
            end
            else if (LW'($unsigned(dot)) >= l2)
            begin
                skip_reg <= 1'b1;
                rx_reg <= vx_reg;
                ry_reg <= vy_reg;
            end
            else
            begin
                skip_reg <= 1'b0;
                rem_reg <= LW'($unsigned(dot));
            end
        end
        if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (shl >= l2_reg)
            begin
                rem_reg <= shl - l2_reg;
                t_reg <= {t_reg[T_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shl;
                t_reg <= {t_reg[T_BITS-2:0], 1'b0};
            end
        end
        if (cmd.proj)
        begin
            rx_reg <= COORD_BITS'(DW'(ax_reg) + DW'(offx));
            ry_reg <= COORD_BITS'(DW'(ay_reg) + DW'(offy));
        end
        if (cmd.dist_calc)
            dist_reg <= LW'($unsigned(PW'(dxn) * PW'(dxn))) +
                        LW'($unsigned(PW'(dyn) * PW'(dyn)));
        if (cmd.emit)
        begin
            found_reg <= best_valid_reg;
            ox_reg <= best_valid_reg ? bx_reg : '0;
            oy_reg <= best_valid_reg ? by_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            best_valid_reg <= 1'b0;
            ax_reg <= '0;
            ay_reg <= '0;
            best_reg <= '1;
            bx_reg <= '0;
            by_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                best_valid_reg <= 1'b0;
                best_reg <= '1;
            end
            if (cmd.cmp && (!best_valid_reg || dist_reg < best_reg))
            begin
                best_valid_reg <= 1'b1;
                best_reg <= dist_reg;
                bx_reg <= rx_reg;
                by_reg <= ry_reg;
            end
            if (cmd.commit_prev)
            begin
                ax_reg <= vx_reg;
                ay_reg <= vy_reg;
                have_prev_reg <= !last_reg;
                if (last_reg)
                begin
                    best_valid_reg <= 1'b0;
                    best_reg <= '1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/closest_point_on_polyline.sv */
// path: a vertex word goes from S_SEG to S_DIV and S_PROJ when the segment goes through the
// divider, or to S_DIV alone when t clamps, then to S_DIST, S_CMP and S_FIN; with no segment straight to S_FIN
// throughput: one vertex word at a time, the next is taken only back in S_IDLE; a divided
// segment goes through the radix-2 divider (one bit of t a cycle)
// a result word held by the receiver stalls the next last vertex word
// reset: asynchronous active low, clears the search and the previous vertex
`default_nettype none
module closest_point_on_polyline #(
    parameter int COORD_BITS = cpp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS = cpp_pkg::FRAC_BITS_DEF,
    parameter int T_BITS = cpp_pkg::T_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    cpp_in_if.sink in_ch,
    cpp_out_if.source out_ch
);
    import cpp_pkg::*;

    cpp_cmd_t cmd;
    cpp_status_t status;

    cpp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .status(status), .cmd(cmd)
    );

    cpp_datapath #(.COORD_BITS(COORD_BITS), .T_BITS(T_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .query_x(in_ch.query_x), .query_y(in_ch.query_y),
        .vertex_x(in_ch.vertex_x), .vertex_y(in_ch.vertex_y),
        .first_vertex(in_ch.first_vertex), .last_vertex(in_ch.last_vertex),
        .cmd(cmd), .status(status),
        .found(out_ch.found), .closest_x(out_ch.closest_x), .closest_y(out_ch.closest_y)
    );
endmodule
`default_nettype wire

/* hdl/cpp_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module cpp_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic found,
    input wire logic [23:0] closest_x
);
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_IMPLIES(a_zero_nf, clk, rst_n, out_valid && !found, closest_x == 24'd0)
    `ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind closest_point_on_polyline cpp_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .found(out_ch.found), .closest_x(out_ch.closest_x[23:0])
);
`default_nettype wire

/* bench/tb_cpp_if.sv */
`timescale 1ns / 100ps
`default_nettype none
// flow control knobs shared by the bench processes
interface tb_cpp_probe_if;
    logic calm;
    logic long_hold;
endinterface
`default_nettype wire

/* bench/tb_closest_point_on_polyline.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_closest_point_on_polyline;
    localparam int CB = cpp_pkg::COORD_BITS_DEF;
    localparam int TB = cpp_pkg::T_BITS_DEF;
    localparam int LIMIT = 400000;

    typedef logic signed [CB-1:0] coord_t;
    typedef struct packed {
        coord_t qx, qy, vx, vy;
        logic first, last;
    } vertex_word_t;
    typedef struct packed {
        logic found;
        coord_t cx, cy;
    } nearest_t;
    typedef struct {
        vertex_word_t w;
        logic known;
        nearest_t r;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int cycles = 0;
    int failures = 0;
    int sent_words = 0;
    logic stim_done = 1'b0;

    tb_cpp_probe_if knobs ();
    cpp_in_if #(.COORD_BITS(CB)) in_ch ();
    cpp_out_if #(.COORD_BITS(CB)) out_ch ();

    closest_point_on_polyline uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // search state
    coord_t last_x, last_y;
    logic seg_open;
    logic [63:0] nearest_d2;
    coord_t nearest_x, nearest_y;
    logic nearest_ok;
    nearest_t expected_q[$];

    function automatic logic [63:0] sq(longint v);
        longint unsigned m;
        m = v < 0 ? -v : v;
        return m * m;
    endfunction

    task automatic clear_search();
        seg_open = 1'b0;
        nearest_d2 = '1;
        nearest_x = '0;
        nearest_y = '0;
        nearest_ok = 1'b0;
    endtask

    function automatic longint scale_t(logic [TB-1:0] t, longint d);
        longint unsigned m;
        m = ({48'd0, t} * (d < 0 ? -d : d)) >> TB;
        return d < 0 ? -longint'(m) : longint'(m);
    endfunction

    task automatic project_segment(vertex_word_t w);
        longint ax, ay, bx, by, abx, aby, apx, apy, rx, ry, dotp;
        logic [63:0] l2, rem, d2;
        logic [TB-1:0] t;
        ax = last_x; ay = last_y; bx = w.vx; by = w.vy;
        abx = bx - ax; aby = by - ay; apx = w.qx - ax; apy = w.qy - ay;
        l2 = sq(abx) + sq(aby);
        dotp = apx * abx + apy * aby;
        rx = ax; ry = ay;
        if (dotp > 0)
        begin
            if (dotp >= longint'(l2))
            begin
                rx = bx; ry = by;
            end
            else
            begin
                rem = dotp;
                t = '0;
                for (int i = 0; i < TB; i++)
                begin
                    rem = rem << 1;
                    t = t << 1;
                    if (rem >= l2)
                    begin
                        rem = rem - l2;
                        t[0] = 1'b1;
                    end
                end
                rx = ax + scale_t(t, abx);
                ry = ay + scale_t(t, aby);
            end
        end
        d2 = sq(w.qx - rx) + sq(w.qy - ry);
        if (!nearest_ok || d2 < nearest_d2)
        begin
            nearest_d2 = d2;
            nearest_x = coord_t'(rx);
            nearest_y = coord_t'(ry);
            nearest_ok = 1'b1;
        end
    endtask

    task automatic predict_nearest(vertex_word_t w, logic known, nearest_t typed);
        nearest_t r;
        if (w.first)
            clear_search();
        if (seg_open)
            project_segment(w);
        last_x = w.vx; last_y = w.vy; seg_open = 1'b1;
        if (w.last)
        begin
            r.found = nearest_ok;
            r.cx = nearest_ok ? nearest_x : '0;
            r.cy = nearest_ok ? nearest_y : '0;
            if (known)
                r = typed;
            expected_q.insert(expected_q.size(), r);
            clear_search();
        end
    endtask

    // directed words, results typed in where obvious
    row_t table_q[$];
    task automatic add_row(coord_t qx, qy, vx, vy, logic f, l, logic k, nearest_t r);
        row_t row;
        row.w = '{qx, qy, vx, vy, f, l};
        row.known = k;
        row.r = r;
        table_q.insert(table_q.size(), row);
    endtask

    localparam coord_t CMAX = 24'sh7fffff;
    localparam coord_t CMIN = -24'sh800000;
    localparam nearest_t NONE = '{1'b0, '0, '0};

    task automatic build_table();
        // lone vertex after reset
        add_row(0, 0, 5, 5, 1, 1, 1, NONE);
        // no first mark, one segment, query at b
        add_row(0, 0, 0, 0, 0, 0, 0, NONE);
        add_row(256, 0, 256, 0, 0, 1, 1, '{1'b1, 24'sd256, 24'sd0});
        // zero-length segment
        add_row(100, 100, 50, 50, 1, 0, 0, NONE);
        add_row(100, 100, 50, 50, 0, 1, 1, '{1'b1, 24'sd50, 24'sd50});
        // extremes, query at a
        add_row(CMIN, CMIN, CMAX, CMAX, 1, 0, 0, NONE);
        add_row(CMAX, CMAX, CMIN, CMIN, 0, 1, 1, '{1'b1, CMAX, CMAX});
        add_row(CMAX, CMIN, CMIN, CMAX, 1, 0, 0, NONE);
        add_row(CMIN, CMAX, CMAX, CMIN, 0, 1, 0, NONE);
        // interior projection, ties, changing query
        add_row(0, 300, 0, 0, 1, 0, 0, NONE);
        add_row(100, 300, 1000, 0, 0, 0, 0, NONE);
        add_row(-77, 5, 1000, 1000, 0, 0, 0, NONE);
        add_row(500, -3, 0, 0, 0, 1, 0, NONE);
        add_row(0, 0, -1, -1, 0, 0, 0, NONE);
        add_row(7, 3, 3, 9, 0, 1, 0, NONE);
        add_row(-500, 400, 1, -1, 1, 0, 0, NONE);
        add_row(-500, 400, 1, -1, 0, 0, 0, NONE);
        add_row(CMAX, CMIN, 12345, -999, 0, 1, 0, NONE);
        // lone vertex with both marks mid-stream
        add_row(1, 1, 1, 1, 1, 1, 1, NONE);
    endtask

    function automatic coord_t rnd_coord();
        case ($urandom_range(0, 5))
            0: return CMAX;
            1: return CMIN;
            2: return coord_t'($urandom_range(0, 2000)) - coord_t'(1000);
            3: return coord_t'($urandom_range(0, 200000)) - coord_t'(100000);
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_word(vertex_word_t w, logic known, nearest_t typed);
        in_ch.valid <= 1'b1;
        {in_ch.query_x, in_ch.query_y, in_ch.vertex_x, in_ch.vertex_y} <=
            {w.qx, w.qy, w.vx, w.vy};
        in_ch.first_vertex <= w.first;
        in_ch.last_vertex <= w.last;
        do @(posedge clk); while (!in_ch.ready);
        predict_nearest(w, known, typed);
        if (!knobs.calm && $urandom_range(0, 99) < 25)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.query_x = '0; in_ch.query_y = '0;
        in_ch.vertex_x = '0; in_ch.vertex_y = '0;
        in_ch.first_vertex = 1'b0; in_ch.last_vertex = 1'b0;
        out_ch.ready = 1'b0;
        knobs.calm = 1'b0;
        knobs.long_hold = 1'b0;
    end

    initial
    begin : stimulus
        vertex_word_t w;
        coord_t qx, qy;
        int len;
        clear_search();
        build_table();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (table_q[i])
            send_word(table_q[i].w, table_q[i].known, table_q[i].r);
        while (sent_words < 1700)
        begin
            if (sent_words > 600 && sent_words < 800) knobs.calm = 1'b1;
            else knobs.calm = 1'b0;
            qx = rnd_coord(); qy = rnd_coord();
            len = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 6);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    qx = rnd_coord(); qy = rnd_coord();
                end
                w.qx = qx; w.qy = qy; w.vx = rnd_coord(); w.vy = rnd_coord();
                w.first = (k == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 30) == 0);
                w.last = (k == len - 1) ? ($urandom_range(0, 15) != 0) : 1'b0;
                send_word(w, 1'b0, NONE);
                sent_words++;
            end
        end
        in_ch.valid <= 1'b0;
        stim_done <= 1'b1;
    end

    // receiver holds off for a long stretch while words keep coming
    initial
    begin : hold_off
        wait (sent_words >= 900);
        @(posedge clk);
        knobs.long_hold <= 1'b1;
        repeat (400) @(posedge clk);
        knobs.long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_ch.ready <= knobs.long_hold ? 1'b0 :
                            (knobs.calm || $urandom_range(0, 99) >= 25);
    end

    always @(posedge clk)
    begin : result_check
        nearest_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected word: found %0b x %0d y %0d",
                       out_ch.found, out_ch.closest_x, out_ch.closest_y);
                failures++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (out_ch.found !== e.found)
                begin
                    $error("found: expected %0b actual %0b", e.found, out_ch.found);
                    failures++;
                end
                if (out_ch.closest_x !== e.cx)
                begin
                    $error("closest_x: expected %0d actual %0d", e.cx, out_ch.closest_x);
                    failures++;
                end
                if (out_ch.closest_y !== e.cy)
                begin
                    $error("closest_y: expected %0d actual %0d", e.cy, out_ch.closest_y);
                    failures++;
                end
            end
        end
    end

    initial
    begin : finish_run
        wait (stim_done);
        while (expected_q.size() != 0 && cycles < LIMIT)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (cycles >= LIMIT || expected_q.size() != 0)
            failures++;
        if (failures == 0)
            $display("PASS closest_point_on_polyline");
        else
            $display("FAIL closest_point_on_polyline");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT + 1000)
        begin
            $display("FAIL closest_point_on_polyline");
            $finish;
        end
    end
endmodule
`default_nettype wire
